// ----- src/urf_pkg.sv -----
// Shared types, codes and helpers for the UART register file.
`default_nettype none
package urf_pkg;

   // command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_RX    = 2'd2;

   // register offsets
   localparam logic [2:0] OFS_DATA  = 3'd0;
   localparam logic [2:0] OFS_IER   = 3'd1;
   localparam logic [2:0] OFS_IIR   = 3'd2;
   localparam logic [2:0] OFS_LCR   = 3'd3;
   localparam logic [2:0] OFS_MCR   = 3'd4;
   localparam logic [2:0] OFS_LSR   = 3'd5;
   localparam logic [2:0] OFS_MSR   = 3'd6;
   localparam logic [2:0] OFS_SCR   = 3'd7;

   // bit positions
   localparam int LCR_DLAB = 7;
   localparam int MCR_LOOP = 4;
   localparam int MCR_OUT2 = 3;
   localparam int FCR_EN   = 0;
   localparam int FCR_RXCLR = 1;
   localparam int IER_RDA  = 0;
   localparam int IER_THRE = 1;
   localparam int IER_RLS  = 2;

   localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
   localparam logic [7:0] IIR_RLS      = 8'h06;
   localparam logic [7:0] IIR_RDA      = 8'h04;
   localparam logic [7:0] IIR_THRE     = 8'h02;
   localparam logic [7:0] IIR_NONE     = 8'h01;
   localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] offset;
      logic [7:0] wr_byte;
      logic [7:0] rx_line_byte;
   } urf_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq;
   } urf_result_type;

   // interrupt identification, highest priority first
   function automatic logic [7:0] urf_iid(input logic [3:0] ier, input logic ovr,
                                          input logic dr, input logic fifo_en);
      logic [7:0] id;
      if (ier[IER_RLS] && ovr) begin
         id = IIR_RLS;
      end else if (ier[IER_RDA] && dr) begin
         id = IIR_RDA;
      end else if (ier[IER_THRE]) begin
         id = IIR_THRE;
      end else begin
         id = IIR_NONE;
      end
      if (fifo_en) begin
         id = id | IIR_FIFO_ON;
      end
      return id;
   endfunction

endpackage
`default_nettype wire

// ----- src/urf_core.sv -----
// Register state and per-word decode/update logic of the UART register file.
`default_nettype none
module urf_core
   import urf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire urf_item_type   item,
   output urf_result_type      result
);

   logic [7:0]  lcr_ff, lcr_in;
   logic [3:0]  ier_ff, ier_in;
   logic [7:0]  fcr_ff, fcr_in;
   logic [4:0]  mcr_ff, mcr_in;
   logic [15:0] dl_ff, dl_in;
   logic [7:0]  scr_ff, scr_in;
   logic [7:0]  rhr_ff, rhr_in;
   logic        dr_ff, dr_in;
   logic        ovr_ff, ovr_in;

   logic       dlab;
   logic       loop;
   logic [7:0] msr;
   logic [7:0] iid_now;
   logic [7:0] iid_next;

   assign dlab = lcr_ff[LCR_DLAB];
   assign loop = mcr_ff[MCR_LOOP];
   assign msr  = loop ? {mcr_ff[3], mcr_ff[2], mcr_ff[0], mcr_ff[1], 4'b0000} : 8'h00;
   assign iid_now = urf_iid(ier_ff, ovr_ff, dr_ff, fcr_ff[FCR_EN]);

   always_comb begin
      lcr_in = lcr_ff;
      ier_in = ier_ff;
      fcr_in = fcr_ff;
      mcr_in = mcr_ff;
      dl_in  = dl_ff;
      scr_in = scr_ff;
      rhr_in = rhr_ff;
      dr_in  = dr_ff;
      ovr_in = ovr_ff;
      result = '0;
      case (item.command)
         CMD_READ: begin
            case (item.offset)
               OFS_DATA: begin
                  if (dlab) begin
                     result.read_data = dl_ff[7:0];
                  end else begin
                     result.read_data = rhr_ff;
                     dr_in = 1'b0;
                  end
               end
               OFS_IER: result.read_data = dlab ? dl_ff[15:8] : {4'b0000, ier_ff};
               OFS_IIR: result.read_data = iid_now;
               OFS_LCR: result.read_data = lcr_ff;
               OFS_MCR: result.read_data = {3'b000, mcr_ff};
               OFS_LSR: begin
                  result.read_data = LSR_TX_EMPTY | {6'b000000, ovr_ff, dr_ff};
                  ovr_in = 1'b0;
               end
               OFS_MSR: result.read_data = msr;
               default: result.read_data = scr_ff;
            endcase
         end
         CMD_WRITE: begin
            case (item.offset)
               OFS_DATA: begin
                  if (dlab) begin
                     dl_in[7:0] = item.wr_byte;
                  end else if (loop) begin
                     ovr_in = ovr_ff | dr_ff;
                     rhr_in = item.wr_byte;
                     dr_in  = 1'b1;
                  end else begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = item.wr_byte;
                  end
               end
               OFS_IER: begin
                  if (dlab) begin
                     dl_in[15:8] = item.wr_byte;
                  end else begin
                     ier_in = item.wr_byte[3:0];
                  end
               end
               OFS_IIR: begin
                  fcr_in = item.wr_byte;
                  if (item.wr_byte[FCR_RXCLR]) begin
                     dr_in = 1'b0;
                  end
               end
               OFS_LCR: lcr_in = item.wr_byte;
               OFS_MCR: mcr_in = item.wr_byte[4:0];
               OFS_SCR: scr_in = item.wr_byte;
               default: ;  // status registers are read-only
            endcase
         end
         CMD_RX: begin
            if (!loop) begin
               ovr_in = ovr_ff | dr_ff;
               rhr_in = item.rx_line_byte;
               dr_in  = 1'b1;
            end
         end
         default: ;
      endcase
      iid_next   = urf_iid(ier_in, ovr_in, dr_in, fcr_in[FCR_EN]);
      result.irq = mcr_in[MCR_OUT2] & ~iid_next[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcr_ff <= '0;
         ier_ff <= '0;
         fcr_ff <= '0;
         mcr_ff <= '0;
         dl_ff  <= '0;
         scr_ff <= '0;
         rhr_ff <= '0;
         dr_ff  <= 1'b0;
         ovr_ff <= 1'b0;
      end else if (step) begin
         lcr_ff <= lcr_in;
         ier_ff <= ier_in;
         fcr_ff <= fcr_in;
         mcr_ff <= mcr_in;
         dl_ff  <= dl_in;
         scr_ff <= scr_in;
         rhr_ff <= rhr_in;
         dr_ff  <= dr_in;
         ovr_ff <= ovr_in;
      end
   end

`ifndef SYNTHESIS
   // an LSR read always leaves overrun clear
   a_lsr_read_clears_ovr: assert property (@(posedge clock) disable iff (reset)
      (step && item.command == CMD_READ && item.offset == OFS_LSR) |=> !ovr_ff)
      else $error("overrun not cleared by LSR read");
   a_loop_no_tx: assert property (@(posedge clock) disable iff (reset)
      (step && loop) |-> !result.tx_valid)
      else $error("tx in loopback");
   a_loop_write_sets_dr: assert property (@(posedge clock) disable iff (reset)
      (step && loop && !dlab && item.command == CMD_WRITE && item.offset == OFS_DATA)
      |=> (dr_ff && rhr_ff == $past(item.wr_byte)))
      else $error("loopback byte lost");
   a_irq_needs_out2: assert property (@(posedge clock) disable iff (reset)
      (step && result.irq) |=> mcr_ff[MCR_OUT2])
      else $error("irq without OUT2");
`endif

endmodule
`default_nettype wire

// ----- src/uart_register_file_with_loopback_top.sv -----
// Top level of the 16550-style UART register file with loopback.
// A request word carries one bus access (read, write) or a byte arriving
// from the serial line; each request yields exactly one response word with
// read data, an optional transmitted byte, and the irq level after the
// access. The path is two registers deep: the request is captured in an
// input register, and the decode and register update run from it and land
// in the response register once that slot is free or draining. One word
// per cycle is sustained; the only limit is rsp_ready. While a finished
// response waits, the input register takes one more word and then
// req_ready stays low until the response drains. Offsets 0/1 go to the
// divisor latch when LCR bit 7 is set; MCR bit 4 loops THR writes into RBR
// and cuts off the line input. No FIFOs or bit timing are modeled; the
// transmitter always reads as empty.
`default_nettype none
module uart_register_file_with_loopback_top
   import urf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [2:0] req_offset,
   input  wire logic [7:0] req_wr_byte,
   input  wire logic [7:0] req_rx_line_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_tx_valid,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_irq
);

   urf_item_type   in_ff;
   logic           in_valid_ff;
   urf_result_type rsp_ff;
   logic           rsp_valid_ff;
   urf_result_type core_result;
   logic           advance;

   // stage 2 moves when the response slot is free or draining this cycle
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // request payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.command      <= req_command;
         in_ff.offset       <= req_offset;
         in_ff.wr_byte      <= req_wr_byte;
         in_ff.rx_line_byte <= req_rx_line_byte;
      end
   end

   urf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_tx_valid  = rsp_ff.tx_valid;
   assign rsp_tx_byte   = rsp_ff.tx_byte;
   assign rsp_irq       = rsp_ff.irq;

`ifndef SYNTHESIS
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending request dropped");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("response overwritten");
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response missing");
`endif

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the 16550-style UART register file with loopback.
`timescale 1ns / 100ps
module tb;
   import urf_pkg::*;

   // the package stops at command 2; the fourth code must do nothing
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 1700;
   localparam int TAIL_WORDS   = 150;      // no idling once this few are left
   localparam int DRAIN_CYCLES = 8;        // two-deep pipe, plus margin
   localparam int CYCLE_LIMIT  = 500000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = CMD_READ;
   logic [2:0] req_offset = OFS_DATA;
   logic [7:0] req_wr_byte = 8'h00;
   logic [7:0] req_rx_line_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_irq;

   uart_register_file_with_loopback_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_offset       (req_offset),
      .req_wr_byte      (req_wr_byte),
      .req_rx_line_byte (req_rx_line_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_tx_valid     (rsp_tx_valid),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_irq          (rsp_irq)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------
   // Mirror of the register file. Updated once per accepted request
   // word, in accept order, so the expected response is known the
   // moment the word goes in.
   // ---------------------------------------------------------------
   logic [7:0]  mir_lcr = '0;
   logic [3:0]  mir_ier = '0;
   logic [7:0]  mir_fcr = '0;
   logic [4:0]  mir_mcr = '0;
   logic [15:0] mir_div = '0;
   logic [7:0]  mir_scr = '0;
   logic [7:0]  mir_rbr = '0;
   logic        mir_ready_flag = 1'b0;
   logic        mir_overrun = 1'b0;

   urf_item_type   req_backlog[$];     // words still to be offered
   urf_result_type rsp_expected[$];    // responses owed by the block

   int errors = 0;
   int words_total = 0;
   int words_sent = 0;
   int words_checked = 0;
   int cycle_count = 0;
   int n_read = 0, n_write = 0, n_line = 0, n_unused = 0;
   int n_tx = 0, n_loop = 0, n_overrun = 0, n_irq = 0, n_dlab = 0;
   bit settle_phase = 1'b0;

   // IIR value: line status, then received data, then THR empty (a
   // level, the transmitter never fills), else no interrupt
   function automatic logic [7:0] mirror_iid();
      logic [7:0] id;
      if (mir_ier[IER_RLS] && mir_overrun) begin
         id = IIR_RLS;
      end else if (mir_ier[IER_RDA] && mir_ready_flag) begin
         id = IIR_RDA;
      end else if (mir_ier[IER_THRE]) begin
         id = IIR_THRE;
      end else begin
         id = IIR_NONE;
      end
      if (mir_fcr[FCR_EN]) begin
         id = id | IIR_FIFO_ON;
      end
      return id;
   endfunction

   // byte into RBR; a second byte before RBR is read marks overrun
   task automatic land_rx_byte(input logic [7:0] b);
      if (mir_ready_flag) begin
         mir_overrun = 1'b1;
         n_overrun++;
      end
      mir_rbr = b;
      mir_ready_flag = 1'b1;
   endtask

   task automatic uart_mirror_step(input urf_item_type w, output urf_result_type r);
      logic       dlab;
      logic [7:0] id;
      dlab = mir_lcr[LCR_DLAB];
      r = '0;
      case (w.command)
         CMD_READ: begin
            n_read++;
            case (w.offset)
               OFS_DATA: begin
                  if (dlab) begin
                     r.read_data = mir_div[7:0];
                  end else begin
                     r.read_data = mir_rbr;
                     mir_ready_flag = 1'b0;
                  end
               end
               OFS_IER: r.read_data = dlab ? mir_div[15:8] : {4'b0, mir_ier};
               OFS_IIR: r.read_data = mirror_iid();
               OFS_LCR: r.read_data = mir_lcr;
               OFS_MCR: r.read_data = {3'b0, mir_mcr};
               OFS_LSR: begin
                  r.read_data = LSR_TX_EMPTY | {6'b0, mir_overrun, mir_ready_flag};
                  mir_overrun = 1'b0;
               end
               OFS_MSR: begin
                  // loopback ties the modem inputs to the MCR outputs
                  if (mir_mcr[MCR_LOOP]) begin
                     r.read_data = {mir_mcr[3], mir_mcr[2], mir_mcr[0], mir_mcr[1], 4'b0};
                  end
               end
               default: r.read_data = mir_scr;
            endcase
         end
         CMD_WRITE: begin
            n_write++;
            if (dlab && (w.offset == OFS_DATA || w.offset == OFS_IER)) begin
               n_dlab++;
            end
            case (w.offset)
               OFS_DATA: begin
                  if (dlab) begin
                     mir_div[7:0] = w.wr_byte;
                  end else if (mir_mcr[MCR_LOOP]) begin
                     n_loop++;
                     land_rx_byte(w.wr_byte);
                  end else begin
                     r.tx_valid = 1'b1;
                     r.tx_byte = w.wr_byte;
                     n_tx++;
                  end
               end
               OFS_IER: begin
                  if (dlab) begin
                     mir_div[15:8] = w.wr_byte;
                  end else begin
                     mir_ier = w.wr_byte[3:0];
                  end
               end
               OFS_IIR: begin
                  mir_fcr = w.wr_byte;
                  if (w.wr_byte[FCR_RXCLR]) begin
                     mir_ready_flag = 1'b0;
                  end
               end
               OFS_LCR: mir_lcr = w.wr_byte;
               OFS_MCR: mir_mcr = w.wr_byte[4:0];
               OFS_SCR: mir_scr = w.wr_byte;
               default: ;  // LSR and MSR are read-only
            endcase
         end
         CMD_RX: begin
            n_line++;
            // receiver is cut off from the line during loopback
            if (!mir_mcr[MCR_LOOP]) begin
               land_rx_byte(w.rx_line_byte);
            end
         end
         default: n_unused++;
      endcase
      id = mirror_iid();
      r.irq = mir_mcr[MCR_OUT2] && !id[0];
      if (r.irq) begin
         n_irq++;
      end
   endtask

   task automatic queue_word(input logic [1:0] c, input logic [2:0] o,
                             input logic [7:0] d, input logic [7:0] b);
      urf_item_type w;
      w.command = c;
      w.offset = o;
      w.wr_byte = d;
      w.rx_line_byte = b;
      req_backlog.push_back(w);
   endtask

   // ---------------------------------------------------------------
   // Request driver. The word on the port is taken at an edge with
   // valid and ready high; the mirror sees it at that same edge. Idle
   // bursts only start while the channel is empty, so valid never drops
   // under a pending word.
   // ---------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin
      urf_item_type   cur;
      urf_item_type   nxt;
      urf_result_type want;
      bit             calm;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            cur = {req_command, req_offset, req_wr_byte, req_rx_line_byte};
            uart_mirror_step(cur, want);
            rsp_expected.push_back(want);
            words_sent++;
         end
         settle_phase = (req_backlog.size() < TAIL_WORDS);
         calm = (words_sent % 500) < 120;
         if (!req_valid || req_ready) begin
            if (req_gap > 0 && !settle_phase) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!settle_phase && !calm && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(1, 19) - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= nxt.command;
               req_offset <= nxt.offset;
               req_wr_byte <= nxt.wr_byte;
               req_rx_line_byte <= nxt.rx_line_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor. Ready drops in random stall bursts; each taken
   // response is checked field by field against the oldest prediction.
   // ---------------------------------------------------------------
   int rsp_stall = 0;

   always @(posedge clock) begin
      urf_result_type want;
      bit             calm;
      bit             tail;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_expected.size() == 0) begin
               $error("response word with no request outstanding");
               errors++;
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  errors++;
               end
               if (rsp_tx_valid !== want.tx_valid) begin
                  $error("tx_valid: expected %b, got %b", want.tx_valid, rsp_tx_valid);
                  errors++;
               end
               if (rsp_tx_byte !== want.tx_byte) begin
                  $error("tx_byte: expected %h, got %h", want.tx_byte, rsp_tx_byte);
                  errors++;
               end
               if (rsp_irq !== want.irq) begin
                  $error("irq: expected %b, got %b", want.irq, rsp_irq);
                  errors++;
               end
            end
            words_checked++;
         end
         calm = (words_checked % 450) < 100;
         tail = (words_total - words_checked) < TAIL_WORDS;
         if (rsp_stall > 0 && !tail) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (!tail && !calm && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int         useful;
      int         roll;
      logic [1:0] cmd;
      logic [2:0] ofs;
      logic [7:0] wd;
      logic [7:0] lb;

      // directed: scratch all-ones, divisor banking, loopback with
      // overrun, line byte ignored in loopback, IIR priorities, FIFO
      // enable bits and RX clear, normal transmit, overrun from the
      // line, writes to status registers, and the unused command
      queue_word(CMD_WRITE, OFS_SCR, 8'hFF, 8'h00);
      queue_word(CMD_READ,  OFS_SCR, 8'h00, 8'h00);
      queue_word(CMD_WRITE, OFS_LCR, 8'h80, 8'h00);
      queue_word(CMD_WRITE, OFS_DATA, 8'h01, 8'h00);
      queue_word(CMD_WRITE, OFS_IER, 8'hFF, 8'h00);
      queue_word(CMD_READ,  OFS_DATA, 8'h00, 8'h00);
      queue_word(CMD_READ,  OFS_IER, 8'h00, 8'h00);
      queue_word(CMD_WRITE, OFS_LCR, 8'h03, 8'h00);
      queue_word(CMD_WRITE, OFS_IER, 8'hFF, 8'h00);
      queue_word(CMD_WRITE, OFS_MCR, 8'hFF, 8'h00);
      queue_word(CMD_READ,  OFS_MSR, 8'h00, 8'h00);
      queue_word(CMD_WRITE, OFS_DATA, 8'hA5, 8'h00);
      queue_word(CMD_WRITE, OFS_DATA, 8'h5A, 8'h00);
      queue_word(CMD_RX,    OFS_DATA, 8'h00, 8'h33);
      queue_word(CMD_READ,  OFS_IIR, 8'h00, 8'h00);
      queue_word(CMD_READ,  OFS_LSR, 8'h00, 8'h00);
      queue_word(CMD_READ,  OFS_DATA, 8'h00, 8'h00);
      queue_word(CMD_WRITE, OFS_IIR, 8'h03, 8'h00);
      queue_word(CMD_READ,  OFS_IIR, 8'h00, 8'h00);
      queue_word(CMD_WRITE, OFS_MCR, 8'h08, 8'h00);
      queue_word(CMD_WRITE, OFS_DATA, 8'hFF, 8'h00);
      queue_word(CMD_RX,    OFS_DATA, 8'h00, 8'hFF);
      queue_word(CMD_RX,    OFS_DATA, 8'h00, 8'h00);
      queue_word(CMD_WRITE, OFS_LSR, 8'hFF, 8'h00);
      queue_word(CMD_UNUSED, 3'd7, 8'hFF, 8'hFF);
      queue_word(CMD_READ,  OFS_LSR, 8'h00, 8'h00);

      // random: mostly bus traffic and line bytes, with THR writes
      // weighted up so loopback and overrun occur often; DLAB is set by
      // only a quarter of LCR writes to keep offsets 0/1 mostly normal
      useful = 0;
      while (useful < RANDOM_WORDS) begin
         roll = $urandom_range(0, 99);
         ofs = 3'($urandom_range(0, 7));
         wd = 8'($urandom_range(0, 255));
         lb = 8'($urandom_range(0, 255));
         if (roll < 30) begin
            cmd = CMD_READ;
         end else if (roll < 55) begin
            cmd = CMD_WRITE;
            if (ofs == OFS_LCR) begin
               wd[LCR_DLAB] = ($urandom_range(0, 3) == 0);
            end
         end else if (roll < 78) begin
            cmd = CMD_RX;
         end else if (roll < 95) begin
            cmd = CMD_WRITE;
            ofs = OFS_DATA;
         end else if (roll < 98) begin
            cmd = CMD_READ;
            ofs = roll[0] ? OFS_LSR : OFS_DATA;
         end else begin
            cmd = CMD_UNUSED;
         end
         if (cmd != CMD_UNUSED) begin
            useful++;
         end
         queue_word(cmd, ofs, wd, lb);
      end
      words_total = req_backlog.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < words_total) begin
         @(posedge clock);
      end
      while (rsp_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d words (%0d reads, %0d writes, %0d line bytes, %0d unused cmd).",
               words_sent, n_read, n_write, n_line, n_unused);
      $display("Seen: %0d tx bytes, %0d loopback, %0d overruns, %0d divisor, %0d irq high.",
               n_tx, n_loop, n_overrun, n_dlab, n_irq);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
